/* design/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ELC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`define ELC_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define ELC_ASSERT(name, clk, rst, prop, msg)

`define ELC_ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

/* design/elc_pkg.sv */
`timescale 1ns / 1ps
package elc_pkg;

   localparam int INDEX_W = 16;
   localparam int COORD_W = 20;
   localparam int LEN_W = 42;
   localparam int COUNT_W = 17;

   localparam int POINT_INDEX_BITS_DEF = 16;
   localparam int COORD_BITS_DEF = 20;

   localparam int RSP_FIFO_DEPTH = 2;
   localparam int FIFO_LEVEL_W = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic [INDEX_W-1:0]        index_a;
      logic [INDEX_W-1:0]        index_b;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by_coord;
      logic signed [COORD_W-1:0] bz;
      logic                      last_edge;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]   edge_len_sq;
      logic               edge_small;
      logic [LEN_W-1:0]   min_len_sq;
      logic [LEN_W-1:0]   max_len_sq;
      logic [COUNT_W-1:0] small_point_count;
      logic               any_small;
      logic               final_res;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]   len_sq;
      logic [INDEX_W-1:0] index_a;
      logic [INDEX_W-1:0] index_b;
      logic               last_edge;
   } item_type;

   typedef struct packed {
      logic [FIFO_LEVEL_W-1:0] level;
      logic                    pop;
   } fifo_status_type;

endpackage

/* design/elc_ram.sv */
`timescale 1ns / 1ps
module elc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/elc_arith.sv */
`timescale 1ns / 1ps
module elc_arith #(
   parameter int COORD_BITS = elc_pkg::COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  elc_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output elc_pkg::item_type  out_data
);

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W = 2 * DIFF_W;

   typedef struct packed {
      logic [elc_pkg::INDEX_W-1:0] index_a;
      logic [elc_pkg::INDEX_W-1:0] index_b;
      logic                        last_edge;
   } tag_type;

   logic signed [COORD_BITS-1:0] ax_c, ay_c, az_c, bx_c, by_c, bz_c;
   logic signed [DIFF_W-1:0]     dx_in, dy_in, dz_in;
   logic signed [DIFF_W-1:0]     dx_ff, dy_ff, dz_ff;
   logic signed [SQ_W-1:0]       prod_x, prod_y, prod_z;
   logic [elc_pkg::LEN_W-1:0]    sqx_in, sqy_in, sqz_in;
   logic [elc_pkg::LEN_W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   logic [elc_pkg::LEN_W-1:0]    len_in, len_ff;
   tag_type                      tag_in, s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                         s1_ready, s2_ready, s3_ready;

   // stage 1: per-axis differences
   assign ax_c = COORD_BITS'($signed(in_data.ax));
   assign ay_c = COORD_BITS'($signed(in_data.ay));
   assign az_c = COORD_BITS'($signed(in_data.az));
   assign bx_c = COORD_BITS'($signed(in_data.bx));
   assign by_c = COORD_BITS'($signed(in_data.by_coord));
   assign bz_c = COORD_BITS'($signed(in_data.bz));

   assign dx_in = DIFF_W'(ax_c) - DIFF_W'(bx_c);
   assign dy_in = DIFF_W'(ay_c) - DIFF_W'(by_c);
   assign dz_in = DIFF_W'(az_c) - DIFF_W'(bz_c);

   assign tag_in.index_a   = in_data.index_a;
   assign tag_in.index_b   = in_data.index_b;
   assign tag_in.last_edge = in_data.last_edge;

   // stage 2: squares
   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;
   assign prod_z = dz_ff * dz_ff;
   assign sqx_in = elc_pkg::LEN_W'(prod_x);
   assign sqy_in = elc_pkg::LEN_W'(prod_y);
   assign sqz_in = elc_pkg::LEN_W'(prod_z);

   // stage 3: sum, wraps at the length width
   assign len_in = sqx_ff + sqy_ff + sqz_ff;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         dz_ff     <= dz_in;
         s1_tag_ff <= tag_in;
      end
      if (s2_ready && s1_valid_ff) begin
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         sqz_ff    <= sqz_in;
         s2_tag_ff <= s1_tag_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         len_ff    <= len_in;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   assign out_valid          = s3_valid_ff;
   assign out_data.len_sq    = len_ff;
   assign out_data.index_a   = s3_tag_ff.index_a;
   assign out_data.index_b   = s3_tag_ff.index_b;
   assign out_data.last_edge = s3_tag_ff.last_edge;

endmodule

/* design/elc_mark.sv */
`timescale 1ns / 1ps
module elc_mark #(
   parameter int POINT_INDEX_BITS = elc_pkg::POINT_INDEX_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [elc_pkg::LEN_W-1:0] threshold,
   input  logic                      item_valid,
   output logic                      item_ready,
   input  elc_pkg::item_type         item_data,
   input  elc_pkg::fifo_status_type  fifo_status,
   output logic                      clearing,
   output logic                      push_valid,
   output elc_pkg::rsp_type          push_data
);

   localparam int DEPTH = 1 << POINT_INDEX_BITS;

   typedef struct packed {
      logic [elc_pkg::LEN_W-1:0] len_sq;
      logic                      is_small;
      logic [elc_pkg::LEN_W-1:0] min_len;
      logic [elc_pkg::LEN_W-1:0] max_len;
      logic                      last_edge;
   } stat_type;

   logic                              clear_ff, clear_in;
   logic [POINT_INDEX_BITS-1:0]       clr_addr_ff, clr_addr_in;
   logic [elc_pkg::LEN_W-1:0]         min_ff, min_in, max_ff, max_in;
   logic [elc_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                              s4_valid_ff, phase_ff;
   stat_type                          s4_stat_ff, stat_in;
   logic [POINT_INDEX_BITS-1:0]       s4_addr_a_ff, s4_addr_b_ff;
   logic                              m1_valid_ff, m1_mark_ff, m1_end_ff;
   logic [POINT_INDEX_BITS-1:0]       m1_addr_ff;
   stat_type                          m1_stat_ff;
   logic                              wmark_valid_ff;
   logic [POINT_INDEX_BITS-1:0]       wmark_addr_ff;
   logic                              item_small, load, issue, op_end, op_mark;
   logic                              credit_ok, marked, set_bit;
   logic [POINT_INDEX_BITS-1:0]       op_addr, ram_wr_addr;
   logic                              ram_wr_en, ram_wr_data, ram_rd_data;
   logic [elc_pkg::FIFO_LEVEL_W-1:0]  occ;

   // bitmap clear sweep after reset
   assign clear_in    = clear_ff && (clr_addr_ff != '1);
   assign clr_addr_in = clr_addr_ff + POINT_INDEX_BITS'(1);
   assign clearing    = clear_ff;

   // threshold and running extremes, taken as the edge enters
   assign item_small = item_data.len_sq < threshold;
   assign min_in = (item_data.len_sq < min_ff) ? item_data.len_sq : min_ff;
   assign max_in = (item_data.len_sq > max_ff) ? item_data.len_sq : max_ff;

   assign stat_in.len_sq    = item_data.len_sq;
   assign stat_in.is_small  = item_small;
   assign stat_in.min_len   = min_in;
   assign stat_in.max_len   = max_in;
   assign stat_in.last_edge = item_data.last_edge;

   // op issue: endpoint a then b for a small edge, one pass-through op otherwise
   assign op_end  = !s4_stat_ff.is_small || phase_ff;
   assign op_mark = s4_stat_ff.is_small;
   assign op_addr = phase_ff ? s4_addr_b_ff : s4_addr_a_ff;

   // results in flight plus queued must fit the response queue
   assign occ = fifo_status.level
              + elc_pkg::FIFO_LEVEL_W'(m1_valid_ff && m1_end_ff)
              - elc_pkg::FIFO_LEVEL_W'(fifo_status.pop);
   assign credit_ok = occ < elc_pkg::FIFO_LEVEL_W'(elc_pkg::RSP_FIFO_DEPTH);

   assign issue      = s4_valid_ff && (!op_end || credit_ok);
   assign item_ready = !s4_valid_ff || (issue && op_end);
   assign load       = item_valid && item_ready;

   // resolve: forward the mark written by the previous op
   assign marked  = ram_rd_data || (wmark_valid_ff && (wmark_addr_ff == m1_addr_ff));
   assign set_bit = m1_valid_ff && m1_mark_ff && !marked;
   assign count_in = (set_bit && (count_ff != '1)) ? count_ff + elc_pkg::COUNT_W'(1)
                                                   : count_ff;

   assign ram_wr_en   = clear_ff || set_bit;
   assign ram_wr_addr = clear_ff ? clr_addr_ff : m1_addr_ff;
   assign ram_wr_data = !clear_ff;

   elc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (op_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         clr_addr_ff    <= '0;
         min_ff         <= '1;
         max_ff         <= '0;
         count_ff       <= '0;
         s4_valid_ff    <= 1'b0;
         phase_ff       <= 1'b0;
         m1_valid_ff    <= 1'b0;
         wmark_valid_ff <= 1'b0;
      end else begin
         clear_ff       <= clear_in;
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         if (load) begin
            min_ff <= min_in;
            max_ff <= max_in;
         end
         count_ff <= count_in;
         if (item_ready) begin
            s4_valid_ff <= item_valid;
         end
         if (load) begin
            phase_ff <= 1'b0;
         end else if (issue && !op_end) begin
            phase_ff <= 1'b1;
         end
         m1_valid_ff    <= issue;
         wmark_valid_ff <= set_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s4_stat_ff   <= stat_in;
         s4_addr_a_ff <= POINT_INDEX_BITS'(item_data.index_a);
         s4_addr_b_ff <= POINT_INDEX_BITS'(item_data.index_b);
      end
      if (issue) begin
         m1_addr_ff <= op_addr;
         m1_mark_ff <= op_mark;
         m1_end_ff  <= op_end;
         m1_stat_ff <= s4_stat_ff;
      end
      wmark_addr_ff <= m1_addr_ff;
   end

   assign push_valid                  = m1_valid_ff && m1_end_ff;
   assign push_data.edge_len_sq       = m1_stat_ff.len_sq;
   assign push_data.edge_small        = m1_stat_ff.is_small;
   assign push_data.min_len_sq        = m1_stat_ff.min_len;
   assign push_data.max_len_sq        = m1_stat_ff.max_len;
   assign push_data.small_point_count = count_in;
   assign push_data.any_small         = count_in != '0;
   assign push_data.final_res         = m1_stat_ff.last_edge;

endmodule

/* design/elc_rsp_fifo.sv */
`timescale 1ns / 1ps
module elc_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  elc_pkg::rsp_type         push_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output elc_pkg::rsp_type         rsp_data,
   output elc_pkg::fifo_status_type status
);

   localparam int PTR_W = $clog2(elc_pkg::RSP_FIFO_DEPTH);
   localparam int LAST = elc_pkg::RSP_FIFO_DEPTH - 1;

   elc_pkg::rsp_type                 entry_ff [elc_pkg::RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [elc_pkg::FIFO_LEVEL_W-1:0] level_ff, level_in;
   logic                             pop;

   assign pop = (level_ff != '0) && rsp_ready;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(LAST)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(LAST)) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign level_in  = level_ff + elc_pkg::FIFO_LEVEL_W'(push_valid)
                    - elc_pkg::FIFO_LEVEL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid    = level_ff != '0;
   assign rsp_data     = entry_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.pop   = pop;

endmodule

/* design/edge_length_check.sv */
// Mesh edge length check. Each request carries one edge (two point indices and
// the signed coordinates of both endpoints) and yields one response in order:
// the squared length, whether it is below the threshold register, the running
// min and max squared length, the number of distinct points touched by small
// edges and an any-small flag; final_res echoes last_edge and nothing is
// cleared except by reset. The point bitmap lives in a single-port-write
// one-port-read RAM of 2**POINT_INDEX_BITS one-bit entries. After reset a
// clear sweep writes it one entry per cycle with req_ready low; the threshold
// register can be written during the sweep. A request passes the difference,
// square and sum stages, the op and resolve registers and the response queue,
// which drives rsp_valid. Throughput is one edge per cycle for edges at or
// above the threshold while the queue has room; a small edge holds its op
// stage for its two bitmap read-modify-writes on the RAM's single write port.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module edge_length_check #(
   parameter int POINT_INDEX_BITS = elc_pkg::POINT_INDEX_BITS_DEF,
   parameter int COORD_BITS       = elc_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  elc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output elc_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_en,
   input  logic [elc_pkg::LEN_W-1:0] csr_write_data
);

   logic [elc_pkg::LEN_W-1:0] threshold_ff;
   logic                      clearing;
   logic                      arith_in_valid, arith_in_ready;
   logic                      item_valid, item_ready;
   elc_pkg::item_type         item_data;
   logic                      push_valid;
   elc_pkg::rsp_type          push_data;
   elc_pkg::fifo_status_type  fifo_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write_en) begin
         threshold_ff <= csr_write_data;
      end
   end

   assign arith_in_valid = req_valid && !clearing;
   assign req_ready      = arith_in_ready && !clearing;

   elc_arith #(
      .COORD_BITS (COORD_BITS)
   ) u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (arith_in_valid),
      .in_ready  (arith_in_ready),
      .in_data   (req_data),
      .out_valid (item_valid),
      .out_ready (item_ready),
      .out_data  (item_data)
   );

   elc_mark #(
      .POINT_INDEX_BITS (POINT_INDEX_BITS)
   ) u_mark (
      .clock       (clock),
      .reset       (reset),
      .threshold   (threshold_ff),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item_data   (item_data),
      .fifo_status (fifo_status),
      .clearing    (clearing),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   elc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .status     (fifo_status)
   );

   `ELC_ASSERT_NEVER(a_fifo_no_overflow, clock, reset, push_valid && (fifo_status.level == elc_pkg::FIFO_LEVEL_W'(elc_pkg::RSP_FIFO_DEPTH)) && !fifo_status.pop, "response queue overflow")
   `ELC_ASSERT(a_small_counts, clock, reset, (rsp_valid && rsp_data.edge_small) |-> rsp_data.any_small, "small edge without marked points")
   `ELC_ASSERT(a_min_le_max, clock, reset, rsp_valid |-> (rsp_data.min_len_sq <= rsp_data.max_len_sq), "running min above running max")

endmodule
